### rtl/core/fbs_pkg.sv
// ----------------------------------------------------------------------------
// fbs_pkg
// Shared types and constants of the frame bit serializer with NRZ-S coding.
// ----------------------------------------------------------------------------
package fbs_pkg;

  localparam int unsigned PreLenW   = 16;
  localparam int unsigned BlockW    = 10;
  localparam int unsigned SyncPatW  = 32;
  localparam int unsigned FetchW    = 10;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CFG_PREAMBLE_LEN = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_BYTES  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_PATTERN = 2'd2;

  localparam logic [PreLenW-1:0]  PreLenRst  = 16'd768;
  localparam logic [BlockW-1:0]   BlockRst   = 10'd650;
  localparam logic [SyncPatW-1:0] SyncPatRst = 32'h1acf_fc1d;

  typedef enum logic [1:0] {
    STAGE_PRE  = 2'd0,
    STAGE_SYNC = 2'd1,
    STAGE_DATA = 2'd2
  } stage_e;

  typedef struct packed {
    logic              line_level;
    logic [FetchW-1:0] fetch_index;
    logic              frame_done;
    logic [1:0]        stage_now;
  } res_t;

endpackage

### rtl/core/frame_bit_serializer_nrzs.sv
// ----------------------------------------------------------------------------
// frame_bit_serializer_nrzs
// Frame serializer: preamble zeros, sync word MSB first, then coded data
// bytes MSB first, all NRZ-S coded (line level toggles on every zero bit).
// ----------------------------------------------------------------------------
// One item is one bit time and gives one result, one item per clock while
// in_stall_o is low: the frame counters, the sync shift register and the
// line level update in the cycle the item is accepted, and the result goes
// to a two-entry output buffer, so in_stall_o is registered and rises only
// when both entries hold results. While stage_now_o is data, fetch_index_o
// tells which byte to present with the next item; a tick without
// data_present_i in the data stage aborts the frame. Configuration is
// written through cfg_we_i at any time the block is idle.
module frame_bit_serializer_nrzs #(
  parameter int unsigned SYNC_BITS       = 32,
  parameter int unsigned MAX_FRAME_BYTES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fbs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fbs_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          data_present_i,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          line_level_o,
  output logic [fbs_pkg::FetchW-1:0]    fetch_index_o,
  output logic                          frame_done_o,
  output logic [1:0]                    stage_now_o
);
  import fbs_pkg::*;

  localparam int unsigned CntW  = $clog2(SYNC_BITS + 1);
  localparam int unsigned BpW   = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned CmpW  = (BpW > BlockW) ? BpW : BlockW;
  localparam int unsigned SpW   = (SYNC_BITS > SyncPatW) ? SYNC_BITS : SyncPatW;

  logic [PreLenW-1:0]   pre_len_q;
  logic [BlockW-1:0]    block_bytes_q;
  logic [SyncPatW-1:0]  sync_pat_q;

  stage_e               stage_q, stage_d;
  logic [PreLenW-1:0]   pre_cnt_q, pre_cnt_d;
  logic [SYNC_BITS-1:0] sync_shift_q, sync_shift_d;
  logic [CntW-1:0]      sync_cnt_q, sync_cnt_d;
  logic [2:0]           bit_pos_q, bit_pos_d;
  logic [BpW-1:0]       byte_pos_q, byte_pos_d;
  logic                 level_q, level_d;

  logic                 in_acc;
  logic [PreLenW-1:0]   pre_cnt_inc;
  logic                 pre_hit;
  logic [CntW-1:0]      sync_cnt_inc;
  logic                 sync_hit;
  logic [2:0]           bit_pos_inc;
  logic                 byte_wrap;
  logic [BpW-1:0]       byte_inc;
  logic                 byte_hit;
  logic [SpW-1:0]       sync_pat_ext;
  logic [CmpW-1:0]      byte_pos_ext;
  logic                 line_bit;
  logic                 done;
  res_t                 res;

  res_t                 out_q, skid_q;
  logic                 out_valid_q, skid_valid_q;
  logic                 out_take;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_len_q     <= PreLenRst;
      block_bytes_q <= BlockRst;
      sync_pat_q    <= SyncPatRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PREAMBLE_LEN: pre_len_q     <= cfg_data_i[PreLenW-1:0];
        CFG_BLOCK_BYTES:  block_bytes_q <= cfg_data_i[BlockW-1:0];
        CFG_SYNC_PATTERN: sync_pat_q    <= cfg_data_i[SyncPatW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;

  assign pre_cnt_inc  = pre_cnt_q + 1'b1;
  assign pre_hit      = pre_cnt_inc >= pre_len_q;
  assign sync_cnt_inc = sync_cnt_q + 1'b1;
  assign sync_hit     = sync_cnt_inc >= CntW'(SYNC_BITS);
  assign bit_pos_inc  = bit_pos_q + 3'd1;
  assign byte_wrap    = (bit_pos_inc == 3'd0);
  assign byte_inc     = (byte_pos_q == BpW'(MAX_FRAME_BYTES - 1)) ? '0 : byte_pos_q + 1'b1;
  assign byte_hit     = CmpW'(byte_inc) >= CmpW'(block_bytes_q);
  assign sync_pat_ext = SpW'(sync_pat_q);

  // next stage
  always_comb begin
    stage_d = stage_q;
    unique case (stage_q)
      STAGE_PRE: begin
        if (pre_hit) stage_d = STAGE_SYNC;
      end
      STAGE_SYNC: begin
        if (sync_hit) stage_d = STAGE_DATA;
      end
      STAGE_DATA: begin
        if (!data_present_i || (byte_wrap && byte_hit)) stage_d = STAGE_PRE;
      end
      default: stage_d = STAGE_PRE;
    endcase
  end

  // counters and shift register
  always_comb begin
    pre_cnt_d    = pre_cnt_q;
    sync_shift_d = sync_shift_q;
    sync_cnt_d   = sync_cnt_q;
    bit_pos_d    = bit_pos_q;
    byte_pos_d   = byte_pos_q;
    case (stage_q)
      STAGE_PRE: begin
        pre_cnt_d = pre_cnt_inc;
        if (pre_hit) begin
          sync_shift_d = sync_pat_ext[SYNC_BITS-1:0];
          sync_cnt_d   = '0;
        end
      end
      STAGE_SYNC: begin
        sync_shift_d = {sync_shift_q[SYNC_BITS-2:0], 1'b0};
        sync_cnt_d   = sync_cnt_inc;
        if (sync_hit) begin
          bit_pos_d  = '0;
          byte_pos_d = '0;
        end
      end
      STAGE_DATA: begin
        if (data_present_i) begin
          bit_pos_d = bit_pos_inc;
          if (byte_wrap) begin
            byte_pos_d = byte_inc;
            if (byte_hit) pre_cnt_d = '0;
          end
        end else begin
          pre_cnt_d = '0;
        end
      end
      default: pre_cnt_d = '0;
    endcase
  end

  // line bit and result
  always_comb begin
    line_bit = 1'b0;
    done     = 1'b0;
    case (stage_q)
      STAGE_PRE:  line_bit = 1'b0;
      STAGE_SYNC: line_bit = sync_shift_q[SYNC_BITS-1];
      STAGE_DATA: begin
        if (data_present_i) begin
          line_bit = data_byte_i[~bit_pos_q];
          done     = byte_wrap && byte_hit;
        end else begin
          done = 1'b1;
        end
      end
      default: done = 1'b1;
    endcase
    level_d      = level_q ^ ~line_bit;
    byte_pos_ext = CmpW'(byte_pos_d);
    res.line_level  = level_d;
    res.fetch_index = (stage_d == STAGE_DATA) ? byte_pos_ext[FetchW-1:0] : '0;
    res.frame_done  = done;
    res.stage_now   = stage_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q      <= STAGE_PRE;
      pre_cnt_q    <= '0;
      sync_shift_q <= '0;
      sync_cnt_q   <= '0;
      bit_pos_q    <= '0;
      byte_pos_q   <= '0;
      level_q      <= 1'b0;
    end else if (in_acc) begin
      stage_q      <= stage_d;
      pre_cnt_q    <= pre_cnt_d;
      sync_shift_q <= sync_shift_d;
      sync_cnt_q   <= sync_cnt_d;
      bit_pos_q    <= bit_pos_d;
      byte_pos_q   <= byte_pos_d;
      level_q      <= level_d;
    end
  end

  // output register with skid entry
  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_take) skid_valid_q <= 1'b0;
      end else if (in_acc) begin
        if (out_valid_q && !out_take) skid_valid_q <= 1'b1;
        else out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) out_q <= skid_q;
    end else if (in_acc) begin
      if (out_valid_q && !out_take) skid_q <= res;
      else out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign line_level_o  = out_q.line_level;
  assign fetch_index_o = out_q.fetch_index;
  assign frame_done_o  = out_q.frame_done;
  assign stage_now_o   = out_q.stage_now;

endmodule

### rtl/core/fbs_checker.sv
// ----------------------------------------------------------------------------
// fbs_checker
// Port-level checks of the frame bit serializer, bound to the top level.
// ----------------------------------------------------------------------------
module fbs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       line_level_o,
  input logic [fbs_pkg::FetchW-1:0] fetch_index_o,
  input logic                       frame_done_o,
  input logic [1:0]                 stage_now_o
);
  import fbs_pkg::*;

  // a finished frame always returns to preamble
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> stage_now_o == STAGE_PRE)
    else $error("frame_done without return to preamble");

  // byte index only runs in the data stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stage_now_o != STAGE_DATA |-> fetch_index_o == '0)
    else $error("fetch_index nonzero outside data stage");

  // input stalls only when the output side is backed up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_level_o)
      && $stable(fetch_index_o) && $stable(frame_done_o) && $stable(stage_now_o))
    else $error("stalled item changed");

endmodule

bind frame_bit_serializer_nrzs fbs_checker u_fbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .line_level_o  (line_level_o),
  .fetch_index_o (fetch_index_o),
  .frame_done_o  (frame_done_o),
  .stage_now_o   (stage_now_o)
);
